[rtl/closest_ray_sphere_hit_macros.svh]
// Assertion macros for the closest ray-sphere hit block.
// Used by rtl/closest_ray_sphere_hit.sv; expects clk and rst_n in scope.
`ifndef CLOSEST_RAY_SPHERE_HIT_MACROS_SVH
`define CLOSEST_RAY_SPHERE_HIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CRSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define CRSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/crsh_pkg.sv]
// Shared constants and types for the closest ray-sphere hit block.
// No dependencies; imported by rtl/closest_ray_sphere_hit.sv.
`default_nettype none
package crsh_pkg;

  localparam int MAX_SPHERES = 64;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

  // Stream payload widths
  localparam int IN_DATA_W  = 296;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_W      = 7;

  // Root numerator and its scaled form
  localparam int N_W   = 68;
  localparam int N2_W  = N_W - 1 + FRAC_BITS;
  localparam int N2H_W = N2_W - 32;

  // Request kinds carried on tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // One table entry
  typedef struct packed {
    logic [30:0] rad;
    logic [31:0] cz;
    logic [31:0] cy;
    logic [31:0] cx;
  } sph_t;

endpackage
`default_nettype wire

[rtl/closest_ray_sphere_hit.sv]
// Closest ray-sphere hit: sphere table memory plus a sequenced solver.
// Depends on crsh_pkg and closest_ray_sphere_hit_macros.svh.
//
// Usage: in_* carries requests, in_tuser[0] selects load (0) or query (1).
// A load writes one table entry in the cycle it is accepted and gives no
// result. A query runs every sphere from index 0 to sphere_count-1 (capped at
// the table depth; none for a zero direction) and gives one result on out_*:
// out_tuser[0] is the hit flag, out_tdata the index and distance (0 on a miss).
// cfg_* writes sphere_count; write it only while no query is in flight.
// No request is taken while a query is in flight; loads can be taken back to
// back. Per sphere, a 64-step square-root loop and up to two 32-step divide
// loops follow the products from one shared 33x33 multiplier. Spheres that
// miss early skip the square-root and divide loops.
// The table lives in one memory with a registered read.
// Reset clears sphere_count, the sequencer and the output valid; table contents
// stay undefined until loaded. A stalled receiver holds the result in the
// output register; the next request is still taken and its result waits.
`default_nettype none
`include "closest_ray_sphere_hit_macros.svh"
module closest_ray_sphere_hit
  import crsh_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // sphere_index[5:0], pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, radius[30:0],
  // t_min, t_max, zero fill
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  // func
  input  wire  [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // hit_index[5:0], hit_distance[31:0], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // hit
  output logic [0:0]            out_tuser,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_W-1:0]      cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AMUL = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CO   = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_ROOT = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_TEST = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // Unpack request fields
  logic [5:0]         f_idx;
  logic signed [31:0] f_pos [3];
  logic signed [31:0] f_dir [3];
  logic [30:0]        f_rad;
  logic [31:0]        f_tmin, f_tmax;
  assign f_idx    = in_tdata[5:0];
  assign f_pos[0] = in_tdata[37:6];
  assign f_pos[1] = in_tdata[69:38];
  assign f_pos[2] = in_tdata[101:70];
  assign f_dir[0] = in_tdata[133:102];
  assign f_dir[1] = in_tdata[165:134];
  assign f_dir[2] = in_tdata[197:166];
  assign f_rad    = in_tdata[228:198];
  assign f_tmin   = in_tdata[260:229];
  assign f_tmax   = in_tdata[292:261];

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CFG_W-1:0] sc_r;
  logic        in_acc;

  sph_t mem [MAX_SPHERES];
  sph_t mem_q_r;

  logic signed [31:0] o_r [3];
  logic signed [31:0] d_r [3];
  logic [31:0]        tmin_r, tmax_r;
  logic signed [32:0] co_r [3];
  logic signed [65:0] h_r;
  logic signed [65:0] cx_r [3];
  logic [62:0]        m_r [3];
  logic [61:0]        rr_r;
  logic [63:0]        a_r;
  logic [127:0]       x2_r, ar2_r;
  logic [127:0]       sq_rem_r, sq_res_r, sq_one_r;
  logic [63:0]        dv_rem_r;
  logic [31:0]        dv_low_r, t_r;
  logic               root_k_r;
  logic               found_r;
  logic [31:0]        best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_hit_r;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  // Shared multiplier: operands chosen by phase and step
  logic signed [32:0] ma, mb;
  logic signed [65:0] p_r;
  logic [63:0]        pu;
  assign pu = p_r[63:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_AMUL: begin
        case (step_r)
          6'd0: begin ma = {d_r[0][31], d_r[0]}; mb = {d_r[0][31], d_r[0]}; end
          6'd1: begin ma = {d_r[1][31], d_r[1]}; mb = {d_r[1][31], d_r[1]}; end
          6'd2: begin ma = {d_r[2][31], d_r[2]}; mb = {d_r[2][31], d_r[2]}; end
          default: ;
        endcase
      end
      S_MUL1: begin
        case (step_r)
          6'd0: begin ma = co_r[0]; mb = {d_r[0][31], d_r[0]}; end
          6'd1: begin ma = co_r[1]; mb = {d_r[1][31], d_r[1]}; end
          6'd2: begin ma = co_r[2]; mb = {d_r[2][31], d_r[2]}; end
          6'd3: begin ma = co_r[2]; mb = {d_r[1][31], d_r[1]}; end
          6'd4: begin ma = co_r[1]; mb = {d_r[2][31], d_r[2]}; end
          6'd5: begin ma = co_r[0]; mb = {d_r[2][31], d_r[2]}; end
          6'd6: begin ma = co_r[2]; mb = {d_r[0][31], d_r[0]}; end
          6'd7: begin ma = co_r[1]; mb = {d_r[0][31], d_r[0]}; end
          6'd8: begin ma = co_r[0]; mb = {d_r[1][31], d_r[1]}; end
          6'd9: begin ma = {2'b00, mem_q_r.rad}; mb = {2'b00, mem_q_r.rad}; end
          default: ;
        endcase
      end
      S_MUL2: begin
        case (step_r)
          6'd0:  begin ma = {1'b0, m_r[0][31:0]};  mb = {1'b0, m_r[0][31:0]}; end
          6'd1:  begin ma = {2'b00, m_r[0][62:32]}; mb = {1'b0, m_r[0][31:0]}; end
          6'd2:  begin ma = {2'b00, m_r[0][62:32]}; mb = {2'b00, m_r[0][62:32]}; end
          6'd3:  begin ma = {1'b0, m_r[1][31:0]};  mb = {1'b0, m_r[1][31:0]}; end
          6'd4:  begin ma = {2'b00, m_r[1][62:32]}; mb = {1'b0, m_r[1][31:0]}; end
          6'd5:  begin ma = {2'b00, m_r[1][62:32]}; mb = {2'b00, m_r[1][62:32]}; end
          6'd6:  begin ma = {1'b0, m_r[2][31:0]};  mb = {1'b0, m_r[2][31:0]}; end
          6'd7:  begin ma = {2'b00, m_r[2][62:32]}; mb = {1'b0, m_r[2][31:0]}; end
          6'd8:  begin ma = {2'b00, m_r[2][62:32]}; mb = {2'b00, m_r[2][62:32]}; end
          6'd9:  begin ma = {1'b0, a_r[31:0]};  mb = {1'b0, rr_r[31:0]}; end
          6'd10: begin ma = {1'b0, a_r[31:0]};  mb = {3'b000, rr_r[61:32]}; end
          6'd11: begin ma = {1'b0, a_r[63:32]}; mb = {1'b0, rr_r[31:0]}; end
          6'd12: begin ma = {1'b0, a_r[63:32]}; mb = {3'b000, rr_r[61:32]}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
  end

  // Derived values for the current sphere
  logic [63:0]  a_sum;
  logic [65:0]  cx_abs [3];
  logic         cx_big;
  logic [127:0] sq_try;
  logic signed [N_W-1:0] n_neg_h, n_s, n_val;
  logic [N2_W-1:0]  n2;
  logic [N2H_W-1:0] n2_hi;
  logic         n2_sat;
  logic [64:0]  dv_try;
  logic         dv_ge;
  logic         t_ok;
  logic         last_sph;

  assign a_sum = a_r + pu;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cx_abs[k] = cx_r[k][65] ? 66'(-cx_r[k]) : 66'(cx_r[k]);
    end
  end
  assign cx_big = (|cx_abs[0][65:63]) || (|cx_abs[1][65:63]) || (|cx_abs[2][65:63]);
  assign sq_try = sq_res_r + sq_one_r;
  assign n_neg_h = -N_W'(h_r);
  assign n_s     = $signed({4'b0000, sq_res_r[63:0]});
  assign n_val   = root_k_r ? (n_neg_h - n_s) : (n_neg_h + n_s);
  assign n2      = {n_val[N_W-2:0], {FRAC_BITS{1'b0}}};
  assign n2_hi   = n2[N2_W-1:32];
  assign n2_sat  = 64'(n2_hi) >= a_r;
  assign dv_try  = {dv_rem_r, dv_low_r[31]};
  assign dv_ge   = dv_try >= {1'b0, a_r};
  assign t_ok    = (t_r >= tmin_r) && (t_r <= tmax_r) && (!found_r || (t_r < best_r));
  assign last_sph = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 6'd1;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_acc && (in_tuser[0] == FUNC_QUERY)) state_nxt = S_AMUL;
      end
      S_AMUL: begin
        if (step_r == 6'd3) begin
          state_nxt = ((a_sum == 64'd0) || (cnt_r == '0)) ? S_DONE : S_RD;
        end
      end
      S_RD:   state_nxt = S_CO;
      S_CO: begin
        step_nxt  = '0;
        state_nxt = S_MUL1;
      end
      S_MUL1: if (step_r == 6'd10) state_nxt = S_CHK;
      S_CHK: begin
        step_nxt = '0;
        if (cx_big) state_nxt = last_sph ? S_DONE : S_RD;
        else state_nxt = S_MUL2;
      end
      S_MUL2: if (step_r == 6'd13) state_nxt = S_CMP;
      S_CMP: begin
        step_nxt = '0;
        if (x2_r > ar2_r) state_nxt = last_sph ? S_DONE : S_RD;
        else state_nxt = S_SQRT;
      end
      S_SQRT: if (step_r == 6'd63) state_nxt = S_ROOT;
      S_ROOT: begin
        step_nxt = '0;
        if (n_val[N_W-1]) begin
          if (root_k_r) state_nxt = last_sph ? S_DONE : S_RD;
        end else if (n2_sat) begin
          state_nxt = S_TEST;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:  if (step_r == 6'd31) state_nxt = S_TEST;
      S_TEST: begin
        if (!root_k_r) state_nxt = S_ROOT;
        else state_nxt = last_sph ? S_DONE : S_RD;
      end
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      sc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) sc_r <= cfg_data;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Sphere table: write on load, registered read per sphere
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser[0] == FUNC_LOAD) && (32'(f_idx) < 32'(MAX_SPHERES))) begin
      mem[IDX_W'(f_idx)] <= '{rad: f_rad, cz: f_pos[2], cy: f_pos[1], cx: f_pos[0]};
    end
    if (state_r == S_RD) mem_q_r <= mem[idx_r];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          for (int k = 0; k < 3; k++) begin
            o_r[k] <= f_pos[k];
            d_r[k] <= f_dir[k];
          end
          tmin_r   <= f_tmin;
          tmax_r   <= f_tmax;
          a_r      <= '0;
          idx_r    <= '0;
          found_r  <= 1'b0;
          best_r   <= '0;
          best_idx_r <= '0;
          cnt_r    <= (CNT_W'(sc_r) > CNT_W'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES)
                                                            : CNT_W'(sc_r);
        end
      end
      S_AMUL: if (step_r != 6'd0) a_r <= a_sum;
      S_CO: begin
        co_r[0] <= $signed({o_r[0][31], o_r[0]}) - $signed({mem_q_r.cx[31], mem_q_r.cx});
        co_r[1] <= $signed({o_r[1][31], o_r[1]}) - $signed({mem_q_r.cy[31], mem_q_r.cy});
        co_r[2] <= $signed({o_r[2][31], o_r[2]}) - $signed({mem_q_r.cz[31], mem_q_r.cz});
      end
      // Accumulate dot and cross products from the registered multiplier output
      S_MUL1: begin
        case (step_r)
          6'd1:  h_r <= p_r;
          6'd2:  h_r <= h_r + p_r;
          6'd3:  h_r <= h_r + p_r;
          6'd4:  cx_r[0] <= p_r;
          6'd5:  cx_r[0] <= cx_r[0] - p_r;
          6'd6:  cx_r[1] <= p_r;
          6'd7:  cx_r[1] <= cx_r[1] - p_r;
          6'd8:  cx_r[2] <= p_r;
          6'd9:  cx_r[2] <= cx_r[2] - p_r;
          6'd10: rr_r <= pu[61:0];
          default: ;
        endcase
      end
      S_CHK: begin
        for (int k = 0; k < 3; k++) m_r[k] <= cx_abs[k][62:0];
        x2_r  <= '0;
        ar2_r <= '0;
        if (cx_big) idx_r <= idx_r + IDX_W'(1);
      end
      // Build |D x CO|^2 and a*R^2 from 32-bit partial products
      S_MUL2: begin
        case (step_r)
          6'd1, 6'd4, 6'd7:    x2_r  <= x2_r + 128'(pu);
          6'd2, 6'd5, 6'd8:    x2_r  <= x2_r + (128'(pu) << 33);
          6'd3, 6'd6, 6'd9:    x2_r  <= x2_r + (128'(pu) << 64);
          6'd10:               ar2_r <= ar2_r + 128'(pu);
          6'd11, 6'd12:        ar2_r <= ar2_r + (128'(pu) << 32);
          6'd13:               ar2_r <= ar2_r + (128'(pu) << 64);
          default: ;
        endcase
      end
      S_CMP: begin
        sq_rem_r <= ar2_r - x2_r;
        sq_res_r <= '0;
        sq_one_r <= 128'(1) << 126;
        root_k_r <= 1'b0;
        if (x2_r > ar2_r) idx_r <= idx_r + IDX_W'(1);
      end
      // One square-root digit per cycle
      S_SQRT: begin
        if (sq_rem_r >= sq_try) begin
          sq_rem_r <= sq_rem_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_one_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_one_r <= sq_one_r >> 2;
      end
      S_ROOT: begin
        dv_rem_r <= 64'(n2_hi);
        dv_low_r <= n2[31:0];
        t_r      <= 32'hFFFF_FFFF;
        if (n_val[N_W-1]) begin
          root_k_r <= 1'b1;
          if (root_k_r) idx_r <= idx_r + IDX_W'(1);
        end
      end
      // One quotient bit per cycle
      S_DIV: begin
        dv_rem_r <= dv_ge ? 64'(dv_try - {1'b0, a_r}) : dv_try[63:0];
        dv_low_r <= dv_low_r << 1;
        t_r      <= {t_r[30:0], dv_ge};
      end
      S_TEST: begin
        if (t_ok) begin
          found_r    <= 1'b1;
          best_r     <= t_r;
          best_idx_r <= idx_r;
        end
        root_k_r <= 1'b1;
        if (root_k_r) idx_r <= idx_r + IDX_W'(1);
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_hit_r  <= found_r;
          out_data_r <= {2'b00, found_r ? best_r : 32'd0,
                         found_r ? 6'(best_idx_r) : 6'd0};
        end
      end
      default: ;
    endcase
  end

  `CRSH_ASSERT_NOW(a_div_nonzero, (state_r == S_DIV) || (state_r == S_SQRT), a_r != 64'd0, "divide or root with zero a")
  `CRSH_ASSERT_NOW(a_idx_range, state_r == S_RD, CNT_W'(idx_r) < cnt_r, "sphere index past count")
  `CRSH_ASSERT_NEXT(a_done_only, (state_r != S_DONE) && !out_valid_r, !out_valid_r, "result without done")
  `CRSH_ASSERT_NOW(a_miss_zero, out_valid_r && !out_hit_r, out_data_r == '0, "miss with nonzero data")

endmodule
`default_nettype wire
